>>> rtl/lru_page_cache_io_lookup_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_PAGE_CACHE_IO_LOOKUP_DEFINES_SVH
`define LRU_PAGE_CACHE_IO_LOOKUP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, command type and state encodings of the page cache.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int CAPACITY  = 1024;
	localparam int MAX_PAGES = 64;
	localparam int ADDR_BITS = 48;

	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int NP_W      = 7;
	localparam int LAST_W    = ADDR_BITS + 1;
	localparam int TAG_W     = LAST_W;
	localparam int LEN_W     = 16;
	localparam int PS_W      = 17;
	localparam int LIM_W     = 11;
	localparam int EVC_W     = 11;
	localparam int TOT_W     = 32;
	localparam int DIV_CNT_W = $clog2(LAST_W);
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP_LIMIT = 1'b1;

	localparam logic [PS_W-1:0]  PAGE_SIZE_RST = PS_W'(64);
	localparam logic [LIM_W-1:0] CAP_LIMIT_RST = LIM_W'(1024);

	typedef struct packed {
		logic [TAG_W-1:0] first;
		logic [NP_W-1:0]  npages;
		logic             too_many;
	} cmd_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_SCAN,
		BS_TALLY,
		BS_PAGE,
		BS_REF_RD,
		BS_REF_LNK,
		BS_REF_APP,
		BS_MISS,
		BS_POP,
		BS_APPEND,
		BS_CHK,
		BS_EV_RD,
		BS_EV_DO,
		BS_DONE
	} back_state_t;

endpackage

>>> rtl/lpc_ram.sv
// ----------------------------------------------------------------------------
// lpc_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lpc_front.sv
// ----------------------------------------------------------------------------
// lpc_front
// Accepts requests and turns them into first page and page count with two
// bit-serial restoring dividers running side by side.
// ----------------------------------------------------------------------------
module lpc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lpc_pkg::ADDR_BITS-1:0] request_lba,
	input  logic [lpc_pkg::LEN_W-1:0]   request_len,
	input  logic [lpc_pkg::PS_W-1:0]    page_size,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lpc_pkg::cmd_t               push_cmd
);

	lpc_pkg::front_state_t state_q, state_d;
	logic [lpc_pkg::LAST_W-1:0]    dvd_a_q, dvd_b_q, diff;
	logic [lpc_pkg::PS_W-1:0]      rem_a_q, rem_b_q;
	logic [lpc_pkg::PS_W:0]        trial_a, trial_b, sub_a, sub_b;
	logic [lpc_pkg::DIV_CNT_W-1:0] step_q;
	logic                          zero_q, too_many;

	assign trial_a = {rem_a_q, dvd_a_q[lpc_pkg::LAST_W-1]};
	assign trial_b = {rem_b_q, dvd_b_q[lpc_pkg::LAST_W-1]};
	assign sub_a   = trial_a - {1'b0, page_size};
	assign sub_b   = trial_b - {1'b0, page_size};

	assign diff     = dvd_b_q - dvd_a_q;
	assign too_many = !zero_q && (diff >= lpc_pkg::LAST_W'(lpc_pkg::MAX_PAGES));

	always_comb begin
		push_cmd.first    = dvd_a_q;
		push_cmd.too_many = too_many;
		if (zero_q || too_many) begin
			push_cmd.npages = '0;
		end else begin
			push_cmd.npages = diff[lpc_pkg::NP_W-1:0] + lpc_pkg::NP_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpc_pkg::FS_IDLE: if (in_valid) state_d = lpc_pkg::FS_DIV;
			lpc_pkg::FS_DIV: begin
				if (step_q == lpc_pkg::DIV_CNT_W'(lpc_pkg::LAST_W - 1)) begin
					state_d = lpc_pkg::FS_PUSH;
				end
			end
			lpc_pkg::FS_PUSH: if (push_ready) state_d = lpc_pkg::FS_IDLE;
			default: state_d = lpc_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			lpc_pkg::FS_IDLE: in_ready = 1'b1;
			lpc_pkg::FS_PUSH: push_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpc_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lpc_pkg::FS_IDLE: begin
				dvd_a_q <= {1'b0, request_lba};
				dvd_b_q <= {1'b0, request_lba} + lpc_pkg::LAST_W'(request_len)
					- lpc_pkg::LAST_W'(1);
				zero_q  <= (request_len == '0);
				rem_a_q <= '0;
				rem_b_q <= '0;
				step_q  <= '0;
			end
			lpc_pkg::FS_DIV: begin
				step_q <= step_q + lpc_pkg::DIV_CNT_W'(1);
				if (!sub_a[lpc_pkg::PS_W]) begin
					rem_a_q <= sub_a[lpc_pkg::PS_W-1:0];
				end else begin
					rem_a_q <= trial_a[lpc_pkg::PS_W-1:0];
				end
				if (!sub_b[lpc_pkg::PS_W]) begin
					rem_b_q <= sub_b[lpc_pkg::PS_W-1:0];
				end else begin
					rem_b_q <= trial_b[lpc_pkg::PS_W-1:0];
				end
				dvd_a_q <= {dvd_a_q[lpc_pkg::LAST_W-2:0], !sub_a[lpc_pkg::PS_W]};
				dvd_b_q <= {dvd_b_q[lpc_pkg::LAST_W-2:0], !sub_b[lpc_pkg::PS_W]};
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/lpc_cmdq.sv
// ----------------------------------------------------------------------------
// lpc_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lpc_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lpc_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output lpc_pkg::cmd_t pop_cmd
);

	lpc_pkg::cmd_t entry_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    count_q;
	logic          push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/lpc_back.sv
// ----------------------------------------------------------------------------
// lpc_back
// Runs each command against the LRU store: one scan of all allocated slots,
// then a refresh or insert per page with least-recent eviction. The recency
// order is a doubly linked list held in memories, freed slots go on a stack.
// ----------------------------------------------------------------------------
`include "lru_page_cache_io_lookup_defines.svh"

module lpc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  lpc_pkg::cmd_t             cmd,
	input  logic [lpc_pkg::LIM_W-1:0] cap_limit,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      io_hit,
	output logic [lpc_pkg::NP_W-1:0]  pages_in_request,
	output logic [lpc_pkg::NP_W-1:0]  request_page_hits,
	output logic [lpc_pkg::NP_W-1:0]  request_page_misses,
	output logic [lpc_pkg::EVC_W-1:0] evicted_pages,
	output logic                      too_many_pages,
	output logic [lpc_pkg::TOT_W-1:0] total_page_hits,
	output logic [lpc_pkg::TOT_W-1:0] total_page_misses,
	output logic [lpc_pkg::TOT_W-1:0] total_io_hits,
	output logic [lpc_pkg::TOT_W-1:0] total_io_misses
);

	function automatic logic [lpc_pkg::TOT_W-1:0] sat_add(
		input logic [lpc_pkg::TOT_W-1:0] a,
		input logic [lpc_pkg::NP_W-1:0]  b
	);
		logic [lpc_pkg::TOT_W:0] s;
		s = {1'b0, a} + (lpc_pkg::TOT_W + 1)'(b);
		return s[lpc_pkg::TOT_W] ? '1 : s[lpc_pkg::TOT_W-1:0];
	endfunction

	lpc_pkg::back_state_t state_q, state_d, ret_q;
	lpc_pkg::cmd_t        cmd_q;

	logic [lpc_pkg::MAX_PAGES-1:0] hitvec_q;
	logic [lpc_pkg::NP_W-1:0]      hits_q, misses;
	logic [lpc_pkg::EVC_W-1:0]     evc_q;
	logic [lpc_pkg::PG_W-1:0]      k_q;
	logic [lpc_pkg::CNT_W-1:0]     scan_q, hw_q, occ_q, sp_q;
	logic                          pend_s1;
	logic [lpc_pkg::SLOT_W-1:0]    slot_s1, head_q, tail_q, s_q;
	logic [lpc_pkg::TOT_W-1:0]     phit_q, pmiss_q, iohit_q, iomiss_q;
	logic                          out_valid_q;

	logic [lpc_pkg::LIM_W-1:0]  lim;
	logic [lpc_pkg::TAG_W-1:0]  page, off;
	logic                       in_range, last_page;

	logic                       tag_we, nxt_we, prv_we, fre_we, sof_we;
	logic [lpc_pkg::SLOT_W-1:0] tag_waddr, tag_raddr, nxt_waddr, nxt_raddr;
	logic [lpc_pkg::SLOT_W-1:0] prv_waddr, prv_raddr, fre_waddr, fre_raddr;
	logic [lpc_pkg::TAG_W:0]    tag_wdata, tag_rdata;
	logic [lpc_pkg::SLOT_W-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
	logic [lpc_pkg::SLOT_W-1:0] fre_wdata, fre_rdata, sof_wdata, sof_rdata;
	logic [lpc_pkg::PG_W-1:0]   sof_waddr, sof_raddr;

	lpc_ram #(.WIDTH(lpc_pkg::TAG_W + 1), .DEPTH(lpc_pkg::CAPACITY)) u_tag (
		.clk, .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);
	lpc_ram #(.WIDTH(lpc_pkg::SLOT_W), .DEPTH(lpc_pkg::CAPACITY)) u_nxt (
		.clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);
	lpc_ram #(.WIDTH(lpc_pkg::SLOT_W), .DEPTH(lpc_pkg::CAPACITY)) u_prv (
		.clk, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);
	lpc_ram #(.WIDTH(lpc_pkg::SLOT_W), .DEPTH(lpc_pkg::CAPACITY)) u_fre (
		.clk, .we(fre_we), .waddr(fre_waddr), .wdata(fre_wdata),
		.raddr(fre_raddr), .rdata(fre_rdata)
	);
	lpc_ram #(.WIDTH(lpc_pkg::SLOT_W), .DEPTH(lpc_pkg::MAX_PAGES)) u_sof (
		.clk, .we(sof_we), .waddr(sof_waddr), .wdata(sof_wdata),
		.raddr(sof_raddr), .rdata(sof_rdata)
	);

	assign lim = (cap_limit > lpc_pkg::LIM_W'(lpc_pkg::CAPACITY)) ?
		lpc_pkg::LIM_W'(lpc_pkg::CAPACITY) : cap_limit;
	assign page      = cmd_q.first + lpc_pkg::TAG_W'(k_q);
	assign off       = tag_rdata[lpc_pkg::TAG_W-1:0] - cmd_q.first;
	assign in_range  = tag_rdata[lpc_pkg::TAG_W] &&
		(off < lpc_pkg::TAG_W'(cmd_q.npages));
	assign last_page = (lpc_pkg::NP_W'(k_q) + lpc_pkg::NP_W'(1) == cmd_q.npages);
	assign misses    = cmd_q.npages - hits_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpc_pkg::BS_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					state_d = cmd.too_many ? lpc_pkg::BS_DONE : lpc_pkg::BS_SCAN;
				end
			end
			lpc_pkg::BS_SCAN: if (scan_q == hw_q && !pend_s1) state_d = lpc_pkg::BS_TALLY;
			lpc_pkg::BS_TALLY: begin
				state_d = (cmd_q.npages == '0) ? lpc_pkg::BS_DONE : lpc_pkg::BS_PAGE;
			end
			lpc_pkg::BS_PAGE: state_d = hitvec_q[k_q] ? lpc_pkg::BS_REF_RD : lpc_pkg::BS_MISS;
			lpc_pkg::BS_REF_RD: begin
				state_d = (sof_rdata == tail_q) ? lpc_pkg::BS_CHK : lpc_pkg::BS_REF_LNK;
			end
			lpc_pkg::BS_REF_LNK: state_d = lpc_pkg::BS_REF_APP;
			lpc_pkg::BS_REF_APP: state_d = lpc_pkg::BS_CHK;
			lpc_pkg::BS_MISS: begin
				if (occ_q == lpc_pkg::CNT_W'(lpc_pkg::CAPACITY)) begin
					state_d = lpc_pkg::BS_EV_RD;
				end else if (sp_q != '0) begin
					state_d = lpc_pkg::BS_POP;
				end else begin
					state_d = lpc_pkg::BS_APPEND;
				end
			end
			lpc_pkg::BS_POP: state_d = lpc_pkg::BS_APPEND;
			lpc_pkg::BS_APPEND: state_d = lpc_pkg::BS_CHK;
			lpc_pkg::BS_CHK: begin
				if (occ_q > lpc_pkg::CNT_W'(lim)) begin
					state_d = lpc_pkg::BS_EV_RD;
				end else begin
					state_d = last_page ? lpc_pkg::BS_DONE : lpc_pkg::BS_PAGE;
				end
			end
			lpc_pkg::BS_EV_RD: state_d = lpc_pkg::BS_EV_DO;
			lpc_pkg::BS_EV_DO: state_d = ret_q;
			lpc_pkg::BS_DONE: state_d = lpc_pkg::BS_IDLE;
			default: state_d = lpc_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		tag_we = 1'b0; tag_waddr = '0; tag_wdata = '0; tag_raddr = '0;
		nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_raddr = '0;
		prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0; prv_raddr = '0;
		fre_we = 1'b0; fre_waddr = '0; fre_wdata = '0; fre_raddr = '0;
		sof_we = 1'b0; sof_waddr = '0; sof_wdata = '0; sof_raddr = '0;
		case (state_q)
			lpc_pkg::BS_IDLE: cmd_ready = !out_valid_q;
			lpc_pkg::BS_SCAN: begin
				tag_raddr = scan_q[lpc_pkg::SLOT_W-1:0];
				sof_we    = pend_s1 && in_range;
				sof_waddr = off[lpc_pkg::PG_W-1:0];
				sof_wdata = slot_s1;
			end
			lpc_pkg::BS_PAGE: sof_raddr = k_q;
			lpc_pkg::BS_REF_RD: begin
				nxt_raddr = sof_rdata;
				prv_raddr = sof_rdata;
			end
			lpc_pkg::BS_REF_LNK: begin
				if (s_q != head_q) begin
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata;
					nxt_wdata = nxt_rdata;
					prv_we    = 1'b1;
					prv_waddr = nxt_rdata;
					prv_wdata = prv_rdata;
				end
			end
			lpc_pkg::BS_REF_APP: begin
				nxt_we    = 1'b1;
				nxt_waddr = tail_q;
				nxt_wdata = s_q;
				prv_we    = 1'b1;
				prv_waddr = s_q;
				prv_wdata = tail_q;
			end
			lpc_pkg::BS_MISS: fre_raddr = lpc_pkg::SLOT_W'(sp_q - lpc_pkg::CNT_W'(1));
			lpc_pkg::BS_APPEND: begin
				tag_we    = 1'b1;
				tag_waddr = s_q;
				tag_wdata = {1'b1, page};
				if (occ_q != '0) begin
					nxt_we    = 1'b1;
					nxt_waddr = tail_q;
					nxt_wdata = s_q;
					prv_we    = 1'b1;
					prv_waddr = s_q;
					prv_wdata = tail_q;
				end
			end
			lpc_pkg::BS_EV_RD: begin
				tag_raddr = head_q;
				nxt_raddr = head_q;
			end
			lpc_pkg::BS_EV_DO: begin
				tag_we    = 1'b1;
				tag_waddr = head_q;
				fre_we    = 1'b1;
				fre_waddr = sp_q[lpc_pkg::SLOT_W-1:0];
				fre_wdata = head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpc_pkg::BS_IDLE;
			ret_q       <= lpc_pkg::BS_CHK;
			hw_q        <= '0;
			occ_q       <= '0;
			sp_q        <= '0;
			phit_q      <= '0;
			pmiss_q     <= '0;
			iohit_q     <= '0;
			iomiss_q    <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				lpc_pkg::BS_IDLE: pend_s1 <= 1'b0;
				lpc_pkg::BS_SCAN: pend_s1 <= (scan_q != hw_q);
				lpc_pkg::BS_TALLY: begin
					phit_q  <= sat_add(phit_q, hits_q);
					pmiss_q <= sat_add(pmiss_q, misses);
					if (misses == '0) begin
						iohit_q <= sat_add(iohit_q, lpc_pkg::NP_W'(1));
					end else begin
						iomiss_q <= sat_add(iomiss_q, lpc_pkg::NP_W'(1));
					end
				end
				lpc_pkg::BS_MISS: begin
					if (occ_q == lpc_pkg::CNT_W'(lpc_pkg::CAPACITY)) begin
						ret_q <= lpc_pkg::BS_MISS;
					end else if (sp_q != '0) begin
						sp_q <= sp_q - lpc_pkg::CNT_W'(1);
					end else begin
						hw_q <= hw_q + lpc_pkg::CNT_W'(1);
					end
				end
				lpc_pkg::BS_APPEND: occ_q <= occ_q + lpc_pkg::CNT_W'(1);
				lpc_pkg::BS_CHK: ret_q <= lpc_pkg::BS_CHK;
				lpc_pkg::BS_EV_DO: begin
					sp_q  <= sp_q + lpc_pkg::CNT_W'(1);
					occ_q <= occ_q - lpc_pkg::CNT_W'(1);
				end
				lpc_pkg::BS_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lpc_pkg::BS_IDLE: begin
				cmd_q    <= cmd;
				hitvec_q <= '0;
				hits_q   <= '0;
				evc_q    <= '0;
				k_q      <= '0;
				scan_q   <= '0;
			end
			lpc_pkg::BS_SCAN: begin
				if (scan_q != hw_q) begin
					scan_q  <= scan_q + lpc_pkg::CNT_W'(1);
					slot_s1 <= scan_q[lpc_pkg::SLOT_W-1:0];
				end
				if (pend_s1 && in_range) begin
					hitvec_q[off[lpc_pkg::PG_W-1:0]] <= 1'b1;
					hits_q <= hits_q + lpc_pkg::NP_W'(1);
				end
			end
			lpc_pkg::BS_REF_RD: s_q <= sof_rdata;
			lpc_pkg::BS_REF_LNK: if (s_q == head_q) head_q <= nxt_rdata;
			lpc_pkg::BS_REF_APP: tail_q <= s_q;
			lpc_pkg::BS_MISS: s_q <= hw_q[lpc_pkg::SLOT_W-1:0];
			lpc_pkg::BS_POP: s_q <= fre_rdata;
			lpc_pkg::BS_APPEND: begin
				tail_q <= s_q;
				if (occ_q == '0) head_q <= s_q;
			end
			lpc_pkg::BS_CHK: begin
				if (!(occ_q > lpc_pkg::CNT_W'(lim)) && !last_page) begin
					k_q <= k_q + lpc_pkg::PG_W'(1);
				end
			end
			lpc_pkg::BS_EV_DO: begin
				head_q <= nxt_rdata;
				if (evc_q != '1) evc_q <= evc_q + lpc_pkg::EVC_W'(1);
				if (in_range) hitvec_q[off[lpc_pkg::PG_W-1:0]] <= 1'b0;
			end
			lpc_pkg::BS_DONE: begin
				too_many_pages      <= cmd_q.too_many;
				io_hit              <= !cmd_q.too_many && (misses == '0);
				pages_in_request    <= cmd_q.too_many ? '0 : cmd_q.npages;
				request_page_hits   <= cmd_q.too_many ? '0 : hits_q;
				request_page_misses <= cmd_q.too_many ? '0 : misses;
				evicted_pages       <= cmd_q.too_many ? '0 : evc_q;
				total_page_hits     <= phit_q;
				total_page_misses   <= pmiss_q;
				total_io_hits       <= iohit_q;
				total_io_misses     <= iomiss_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	// Every allocated slot is either live or on the free stack between commands.
	`LPC_ASSERT(a_slot_account, state_q == lpc_pkg::BS_IDLE |-> (lpc_pkg::CNT_W + 1)'(sp_q) + (lpc_pkg::CNT_W + 1)'(occ_q) == (lpc_pkg::CNT_W + 1)'(hw_q), "slot accounting broken")
	// Moving on to the next page means the occupancy is back within the limit.
	`LPC_ASSERT(a_within_limit, (state_q == lpc_pkg::BS_CHK && state_d != lpc_pkg::BS_EV_RD) |-> occ_q <= lpc_pkg::CNT_W'(lim), "occupancy above limit")
	// A command is only taken while the result register is empty.
	`LPC_ASSERT(a_pop_empty, cmd_valid && cmd_ready |=> !out_valid_q || $past(state_d == lpc_pkg::BS_DONE), "command taken over a pending result")
	// The result register is empty while reset is applied.
	`LPC_ASSERT_ALWAYS(a_reset_out, !arst_n |-> !out_valid_q, "result valid in reset")

endmodule

>>> rtl/lru_page_cache_io_lookup.sv
// ----------------------------------------------------------------------------
// lru_page_cache_io_lookup
// Fully associative LRU page cache driven by block I/O requests.
//
// An item on the in channel (request_lba, request_len) is taken when
// in_valid and in_ready are both high. One result item per request leaves
// on the out channel, taken when out_valid and out_ready are both high.
// Registers are written through cfg_valid/cfg_ready with cfg_index
// selecting page size or capacity limit; cfg_ready is always high.
// The front divides the first and last address by the page size, one
// quotient bit per cycle, then hands the command to a two-entry queue and
// takes the next item. The back scans every slot ever allocated once (one
// slot a cycle), then refreshes or inserts each page in turn, evicting the
// least recent page where the store is full or over its limit.
// Reset empties the store, zeroes the counters and loads page size 64 and
// capacity limit 1024. A stalled out channel holds the result; the back
// then waits and the front keeps filling the queue.
// ----------------------------------------------------------------------------
module lru_page_cache_io_lookup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpc_pkg::ADDR_BITS-1:0] request_lba,
	input  logic [lpc_pkg::LEN_W-1:0]     request_len,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpc_pkg::PS_W-1:0]      cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          io_hit,
	output logic [lpc_pkg::NP_W-1:0]      pages_in_request,
	output logic [lpc_pkg::NP_W-1:0]      request_page_hits,
	output logic [lpc_pkg::NP_W-1:0]      request_page_misses,
	output logic [lpc_pkg::EVC_W-1:0]     evicted_pages,
	output logic                          too_many_pages,
	output logic [lpc_pkg::TOT_W-1:0]     total_page_hits,
	output logic [lpc_pkg::TOT_W-1:0]     total_page_misses,
	output logic [lpc_pkg::TOT_W-1:0]     total_io_hits,
	output logic [lpc_pkg::TOT_W-1:0]     total_io_misses
);

	logic [lpc_pkg::PS_W-1:0]  page_size_q, page_size_eff;
	logic [lpc_pkg::LIM_W-1:0] cap_limit_q;
	logic                      push_valid, push_ready, pop_valid, pop_ready;
	lpc_pkg::cmd_t             push_cmd, pop_cmd;

	assign cfg_ready     = 1'b1;
	assign page_size_eff = (page_size_q == '0) ? lpc_pkg::PS_W'(1) : page_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= lpc_pkg::PAGE_SIZE_RST;
			cap_limit_q <= lpc_pkg::CAP_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpc_pkg::REG_PAGE_SIZE: page_size_q <= cfg_data;
				lpc_pkg::REG_CAP_LIMIT: cap_limit_q <= cfg_data[lpc_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	lpc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .request_lba, .request_len,
		.page_size(page_size_eff), .push_valid, .push_ready, .push_cmd
	);

	lpc_cmdq u_cmdq (
		.clk, .arst_n, .push_valid, .push_ready, .push_cmd,
		.pop_valid, .pop_ready, .pop_cmd
	);

	lpc_back u_back (
		.clk, .arst_n, .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd(pop_cmd),
		.cap_limit(cap_limit_q), .out_valid, .out_ready, .io_hit,
		.pages_in_request, .request_page_hits, .request_page_misses,
		.evicted_pages, .too_many_pages, .total_page_hits, .total_page_misses,
		.total_io_hits, .total_io_misses
	);

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LRU page cache I/O lookup block.
//
// A short directed table covers empty requests, single pages, requests of
// exactly and just over the page limit, and requests at the top of the
// address range. Random requests then run through several page size and
// capacity settings, from the extremes to ordinary values. Each accepted
// request is predicted by a local LRU store model, and each result item is
// compared field by field with the oldest prediction. Both channels idle in
// random bursts, and once the receiver holds off long enough to back up
// the whole block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 2000;

	typedef struct packed {
		logic             io_hit;
		logic [NP_W-1:0]  pages;
		logic [NP_W-1:0]  page_hits;
		logic [NP_W-1:0]  page_misses;
		logic [EVC_W-1:0] evicted;
		logic             too_many;
		logic [TOT_W-1:0] tot_page_hits;
		logic [TOT_W-1:0] tot_page_misses;
		logic [TOT_W-1:0] tot_io_hits;
		logic [TOT_W-1:0] tot_io_misses;
	} lookup_t;

	typedef struct {
		logic [ADDR_BITS-1:0] lba;
		logic [LEN_W-1:0]     len;
		bit                   typed;
		logic                 hit;
		logic [NP_W-1:0]      pages;
		logic                 too_many;
	} directed_t;

	typedef struct {
		int unsigned size;
		int unsigned limit;
		int unsigned window;
		int unsigned items;
		bit          idle;
		bit          hold;
	} phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ADDR_BITS-1:0] request_lba = '0;
	logic [LEN_W-1:0]     request_len = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_PAGE_SIZE;
	logic [PS_W-1:0]      cfg_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	lookup_t              got;

	lru_page_cache_io_lookup uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.request_lba(request_lba), .request_len(request_len),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.io_hit(got.io_hit), .pages_in_request(got.pages),
		.request_page_hits(got.page_hits), .request_page_misses(got.page_misses),
		.evicted_pages(got.evicted), .too_many_pages(got.too_many),
		.total_page_hits(got.tot_page_hits), .total_page_misses(got.tot_page_misses),
		.total_io_hits(got.tot_io_hits), .total_io_misses(got.tot_io_misses)
	);

	// Local copy of the cache: recency stamps per page, pages per stamp.
	longint unsigned   stamp_of_page[logic [TAG_W-1:0]];
	logic [TAG_W-1:0]  page_at_stamp[longint unsigned];
	longint unsigned   next_stamp = 0;
	logic [PS_W-1:0]   page_size = PAGE_SIZE_RST;
	logic [LIM_W-1:0]  cap_limit = CAP_LIMIT_RST;
	logic [TOT_W-1:0]  page_hit_total = '0, page_miss_total = '0;
	logic [TOT_W-1:0]  io_hit_total = '0, io_miss_total = '0;

	lookup_t   expected_lookups[$];
	directed_t typed_rows[$];
	int        errors = 0;
	int        quiet_cycles = 0;
	bit        idle_en = 1'b0;
	bit        hold_req = 1'b0;

	function automatic logic [TOT_W-1:0] sat_inc(logic [TOT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void drop_oldest_page();
		longint unsigned s;
		void'(page_at_stamp.first(s));
		stamp_of_page.delete(page_at_stamp[s]);
		page_at_stamp.delete(s);
	endfunction

	function automatic lookup_t lookup_request(logic [ADDR_BITS-1:0] lba,
			logic [LEN_W-1:0] len);
		lookup_t          r;
		longint unsigned  ps, last, first, np, lim, ev;
		logic [TAG_W-1:0] pg;
		r = '0;
		ps = (page_size == 0) ? 1 : page_size;
		lim = (cap_limit > CAPACITY) ? CAPACITY : cap_limit;
		first = 0;
		np = 0;
		ev = 0;
		if (len != 0) begin
			last = longint'(lba) + len - 1;
			first = longint'(lba) / ps;
			np = last / ps - first + 1;
			r.too_many = (np > MAX_PAGES);
		end
		if (!r.too_many) begin
			for (longint unsigned k = 0; k < np; k++) begin
				pg = TAG_W'(first + k);
				if (stamp_of_page.exists(pg)) begin
					r.page_hits++;
					page_hit_total = sat_inc(page_hit_total);
				end else begin
					r.page_misses++;
					page_miss_total = sat_inc(page_miss_total);
				end
			end
			r.io_hit = (r.page_misses == 0);
			if (r.io_hit)
				io_hit_total = sat_inc(io_hit_total);
			else
				io_miss_total = sat_inc(io_miss_total);
			for (longint unsigned k = 0; k < np; k++) begin
				pg = TAG_W'(first + k);
				if (stamp_of_page.exists(pg)) begin
					page_at_stamp.delete(stamp_of_page[pg]);
				end else if (stamp_of_page.num() >= CAPACITY) begin
					drop_oldest_page();
					ev++;
				end
				stamp_of_page[pg] = next_stamp;
				page_at_stamp[next_stamp] = pg;
				next_stamp++;
				while (stamp_of_page.num() > lim) begin
					drop_oldest_page();
					ev++;
				end
			end
			r.pages = NP_W'(np);
		end
		r.evicted = (ev > 2047) ? EVC_W'(2047) : EVC_W'(ev);
		r.tot_page_hits = page_hit_total;
		r.tot_page_misses = page_miss_total;
		r.tot_io_hits = io_hit_total;
		r.tot_io_misses = io_miss_total;
		return r;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		lookup_t   p;
		directed_t row;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding",
					$time, expected_lookups.size());
				$display("TB_ERROR");
				$finish;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PAGE_SIZE)
					page_size = cfg_data;
				else
					cap_limit = cfg_data[LIM_W-1:0];
			end
			if (in_valid && in_ready) begin
				p = lookup_request(request_lba, request_len);
				expected_lookups.push_back(p);
				if (typed_rows.size() > 0) begin
					row = typed_rows.pop_front();
					if (row.typed && (p.io_hit !== row.hit || p.pages !== row.pages ||
							p.too_many !== row.too_many)) begin
						$display("%0t: lookup of %h/%0d: expected hit %b pages %0d flag %b, predicted %b %0d %b",
							$time, row.lba, row.len, row.hit, row.pages, row.too_many,
							p.io_hit, p.pages, p.too_many);
						errors++;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, got);
					errors++;
				end else begin
					p = expected_lookups.pop_front();
					if (got.io_hit !== p.io_hit) begin
						$display("%0t: io_hit expected %0d actual %0d", $time, p.io_hit, got.io_hit);
						errors++;
					end
					if (got.pages !== p.pages) begin
						$display("%0t: pages_in_request expected %0d actual %0d",
							$time, p.pages, got.pages);
						errors++;
					end
					if (got.page_hits !== p.page_hits) begin
						$display("%0t: request_page_hits expected %0d actual %0d",
							$time, p.page_hits, got.page_hits);
						errors++;
					end
					if (got.page_misses !== p.page_misses) begin
						$display("%0t: request_page_misses expected %0d actual %0d",
							$time, p.page_misses, got.page_misses);
						errors++;
					end
					if (got.evicted !== p.evicted) begin
						$display("%0t: evicted_pages expected %0d actual %0d",
							$time, p.evicted, got.evicted);
						errors++;
					end
					if (got.too_many !== p.too_many) begin
						$display("%0t: too_many_pages expected %0d actual %0d",
							$time, p.too_many, got.too_many);
						errors++;
					end
					if (got.tot_page_hits !== p.tot_page_hits) begin
						$display("%0t: total_page_hits expected %0d actual %0d",
							$time, p.tot_page_hits, got.tot_page_hits);
						errors++;
					end
					if (got.tot_page_misses !== p.tot_page_misses) begin
						$display("%0t: total_page_misses expected %0d actual %0d",
							$time, p.tot_page_misses, got.tot_page_misses);
						errors++;
					end
					if (got.tot_io_hits !== p.tot_io_hits) begin
						$display("%0t: total_io_hits expected %0d actual %0d",
							$time, p.tot_io_hits, got.tot_io_hits);
						errors++;
					end
					if (got.tot_io_misses !== p.tot_io_misses) begin
						$display("%0t: total_io_misses expected %0d actual %0d",
							$time, p.tot_io_misses, got.tot_io_misses);
						errors++;
					end
				end
			end
		end
	end

	// Result receiver: random stall bursts, and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_request(logic [ADDR_BITS-1:0] lba, logic [LEN_W-1:0] len);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		request_lba <= lba;
		request_len <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [PS_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		directed_t            rows[$];
		phase_t               phases[$];
		logic [ADDR_BITS-1:0] base, lba;
		logic [LEN_W-1:0]     len;
		longint unsigned      ps, span;
		int unsigned          pick;

		// Reset settings: 64 units per page, full capacity.
		rows = '{
			'{48'h0,            16'd0,     1, 1'b1, 7'd0,  1'b0},
			'{48'h0,            16'd1,     1, 1'b0, 7'd1,  1'b0},
			'{48'h0,            16'd64,    1, 1'b1, 7'd1,  1'b0},
			'{48'd63,           16'd2,     1, 1'b0, 7'd2,  1'b0},
			'{48'h0,            16'd4096,  1, 1'b0, 7'd64, 1'b0},
			'{48'd1,            16'd4096,  1, 1'b0, 7'd0,  1'b1},
			'{48'hFFFFFFFFFFFF, 16'hFFFF,  1, 1'b0, 7'd0,  1'b1},
			'{48'hFFFFFFFFFFFF, 16'd1,     1, 1'b0, 7'd1,  1'b0},
			'{48'hFFFFFFFFFFFF, 16'd1,     1, 1'b1, 7'd1,  1'b0},
			'{48'h0,            16'hFFFF,  1, 1'b0, 7'd0,  1'b1},
			'{48'd64,           16'd4032,  1, 1'b1, 7'd63, 1'b0},
			'{48'hFFFFFFFFF000, 16'd4096,  1, 1'b0, 7'd64, 1'b0},
			'{48'h123456789ABC, 16'd777,   0, 1'b0, 7'd0,  1'b0},
			'{48'h800000000000, 16'h8000,  0, 1'b0, 7'd0,  1'b0},
			'{48'hFFFFFFFFF000, 16'd100,   0, 1'b0, 7'd0,  1'b0}
		};
		phases = '{
			'{64,     1024, 200,  140, 1, 0},
			'{1,      8,    40,   140, 1, 0},
			'{65536,  1,    20,   120, 1, 0},
			'{0,      0,    30,   100, 1, 0},
			'{131071, 2047, 3000, 200, 1, 1},
			'{4096,   100,  300,  200, 1, 0},
			'{512,    1024, 1500, 200, 0, 0}
		};

		@(posedge arst_n);
		@(posedge clk);
		idle_en = 1'b1;
		foreach (rows[i]) begin
			typed_rows.push_back(rows[i]);
			send_request(rows[i].lba, rows[i].len);
		end

		foreach (phases[ph]) begin
			write_register(REG_PAGE_SIZE, PS_W'(phases[ph].size));
			write_register(REG_CAP_LIMIT, PS_W'(phases[ph].limit));
			idle_en = phases[ph].idle;
			ps = (phases[ph].size == 0) ? 1 : phases[ph].size;
			span = ps * 6;
			if (span > 65535)
				span = 65535;
			base = {$urandom, $urandom};
			for (int n = 0; n < phases[ph].items; n++) begin
				if (phases[ph].hold && n == 20)
					hold_req = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					lba = {$urandom, $urandom};
					len = '0;
				end else if (pick < 15) begin
					lba = {$urandom, $urandom};
					len = $urandom;
				end else begin
					lba = base + ADDR_BITS'($urandom_range(0, phases[ph].window - 1)) * ps
						+ ADDR_BITS'($urandom_range(0, 32'(ps - 1)));
					len = LEN_W'($urandom_range(1, 32'(span)));
				end
				send_request(lba, len);
			end
		end
		in_valid <= 1'b0;

		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
